@@ hdl/cfe_pkg.sv @@
// Shared types, constants and helper functions of the color fade encoder.
package cfe_pkg;

  // Fixed widths of the datapath
  localparam int LVL_W  = 8;
  localparam int STEP_W = 7;
  localparam int DIV_W  = 16;
  localparam int QUO_W  = DIV_W + 1;
  localparam int ACC_W  = 25;

  // Fade step count saturates here
  localparam logic [STEP_W-1:0] MAX_STEPS = 7'd64;

  // Configuration register indexes
  localparam logic [7:0] REG_SMOOTH_STEPS = 8'd0;
  localparam logic [7:0] REG_RGB_ORDER    = 8'd1;

  // UART byte layout: fixed bits and the three data bit positions
  localparam logic [7:0] BASE_BITS  = 8'b0001_0010;
  localparam logic [7:0] FIRST_BIT  = 8'b0000_0100;
  localparam logic [7:0] SECOND_BIT = 8'b0010_0000;
  localparam logic [7:0] THIRD_BIT  = 8'b1000_0000;

  typedef struct packed {
    logic [7:0] hold_time;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmd_t;

  typedef struct packed {
    logic [63:0] encoded_frame;
    logic [7:0]  show_time;
    logic        last_frame;
  } res_t;

  typedef struct packed {
    logic [STEP_W-1:0] smooth_steps;
    logic              rgb_order;
  } cfg_t;

  // One classified command, handed from front to back
  typedef struct packed {
    logic [7:0]              hold_time;
    logic [LVL_W-1:0]        tgt_r;
    logic [LVL_W-1:0]        tgt_g;
    logic [LVL_W-1:0]        tgt_b;
    logic [LVL_W-1:0]        prev_r;
    logic [LVL_W-1:0]        prev_g;
    logic [LVL_W-1:0]        prev_b;
    logic signed [QUO_W-1:0] step_r;
    logic signed [QUO_W-1:0] step_g;
    logic signed [QUO_W-1:0] step_b;
    logic [STEP_W-1:0]       steps;
  } job_t;

  // Three bits per UART byte, word MSB first
  function automatic logic [63:0] pack_frame(input logic [23:0] word);
    logic [63:0] frame;
    logic [2:0]  tri_bits;
    logic [7:0]  b;
    frame = '0;
    for (int i = 0; i < 8; i++) begin
      tri_bits = word[21 - 3*i +: 3];
      b = BASE_BITS;
      if (tri_bits[2]) b = b | FIRST_BIT;
      if (tri_bits[1]) b = b | SECOND_BIT;
      if (tri_bits[0]) b = b | THIRD_BIT;
      frame[8*i +: 8] = b;
    end
    return frame;
  endfunction

  // Channel order then packing
  function automatic logic [63:0] color_frame(input logic order,
                                              input logic [7:0] r,
                                              input logic [7:0] g,
                                              input logic [7:0] b);
    logic [23:0] word;
    word = order ? {r, g, b} : {g, r, b};
    return pack_frame(word);
  endfunction

  // 8.8 accumulator to level: truncation toward zero, clamped to 0..255
  function automatic logic [LVL_W-1:0] acc_level(input logic signed [ACC_W-1:0] acc);
    logic [LVL_W-1:0] lvl;
    if (acc[ACC_W-1]) lvl = '0;
    else if (|acc[ACC_W-2:16]) lvl = '1;
    else lvl = acc[15:8];
    return lvl;
  endfunction

endpackage

@@ hdl/cfe_div.sv @@
// Bit-serial signed divider for the per-channel fade step.
module cfe_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [cfe_pkg::DIV_W-1:0]       dividend_mag,
  input  logic                            negative,
  input  logic [cfe_pkg::STEP_W-1:0]      divisor,
  output logic                            done,
  output logic signed [cfe_pkg::QUO_W-1:0] quotient
);
  import cfe_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic              active;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_W-1:0]  quo;
  logic [STEP_W-1:0] rem;
  logic [STEP_W-1:0] dvs;
  logic              neg;
  logic [STEP_W:0]   trial;
  logic              fits;

  // One restoring step per cycle
  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        quo    <= dividend_mag;
        rem    <= '0;
        neg    <= negative;
        dvs    <= divisor;
      end else if (active) begin
        rem <= fits ? STEP_W'(trial - {1'b0, dvs}) : trial[STEP_W-1:0];
        quo <= {quo[DIV_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Sign applied after the magnitude divide: truncates toward zero
  assign quotient = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

endmodule

@@ hdl/cfe_front.sv @@
// Front end: accepts commands, saturates the step count, divides out the fade steps.
module cfe_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cfe_pkg::cmd_t     in_data,
  input  cfe_pkg::cfg_t     cfg,
  input  logic              q_full,
  output logic              q_push,
  output cfe_pkg::job_t     q_data
);
  import cfe_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_PUSH} state_t;

  state_t            state;
  job_t              job;
  logic [LVL_W-1:0]  prev_r, prev_g, prev_b;
  logic              accept;
  logic [STEP_W-1:0] steps_sat;
  logic              div_start;
  logic [LVL_W:0]    diff_r, diff_g, diff_b;
  logic [LVL_W:0]    abs_r, abs_g, abs_b;
  logic              done_r, done_g, done_b;
  logic signed [QUO_W-1:0] quo_r, quo_g, quo_b;

  assign in_ready = (state == ST_IDLE) && !rst;
  assign accept   = in_valid && in_ready;

  assign steps_sat = (cfg.smooth_steps > MAX_STEPS) ? MAX_STEPS : cfg.smooth_steps;
  assign div_start = accept && (steps_sat > STEP_W'(1));

  // Signed color differences as sign and magnitude
  assign diff_r = {1'b0, in_data.red}   - {1'b0, prev_r};
  assign diff_g = {1'b0, in_data.green} - {1'b0, prev_g};
  assign diff_b = {1'b0, in_data.blue}  - {1'b0, prev_b};
  assign abs_r  = diff_r[LVL_W] ? -diff_r : diff_r;
  assign abs_g  = diff_g[LVL_W] ? -diff_g : diff_g;
  assign abs_b  = diff_b[LVL_W] ? -diff_b : diff_b;

  cfe_div u_div_r (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend_mag({abs_r[LVL_W-1:0], 8'h00}), .negative(diff_r[LVL_W]),
    .divisor(steps_sat), .done(done_r), .quotient(quo_r)
  );
  cfe_div u_div_g (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend_mag({abs_g[LVL_W-1:0], 8'h00}), .negative(diff_g[LVL_W]),
    .divisor(steps_sat), .done(done_g), .quotient(quo_g)
  );
  cfe_div u_div_b (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend_mag({abs_b[LVL_W-1:0], 8'h00}), .negative(diff_b[LVL_W]),
    .divisor(steps_sat), .done(done_b), .quotient(quo_b)
  );

  assign q_push = (state == ST_PUSH) && !q_full;
  assign q_data = job;

  // Command sequencer and previous color
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      prev_r <= '0;
      prev_g <= '0;
      prev_b <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            job.hold_time <= in_data.hold_time;
            job.tgt_r     <= in_data.red;
            job.tgt_g     <= in_data.green;
            job.tgt_b     <= in_data.blue;
            job.prev_r    <= prev_r;
            job.prev_g    <= prev_g;
            job.prev_b    <= prev_b;
            job.step_r    <= '0;
            job.step_g    <= '0;
            job.step_b    <= '0;
            job.steps     <= steps_sat;
            state         <= div_start ? ST_DIV : ST_PUSH;
          end
        end
        ST_DIV: begin
          if (done_r && done_g && done_b) begin
            job.step_r <= quo_r;
            job.step_g <= quo_g;
            job.step_b <= quo_b;
            state      <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!q_full) begin
            // fading off keeps the old start color
            if (job.steps != '0) begin
              prev_r <= job.tgt_r;
              prev_g <= job.tgt_g;
              prev_b <= job.tgt_b;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/cfe_fifo.sv @@
// Two-entry show-ahead queue of classified commands between front and back.
module cfe_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cfe_pkg::job_t push_data,
  input  logic          pop,
  output cfe_pkg::job_t head,
  output logic          full,
  output logic          empty
);
  import cfe_pkg::*;

  job_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/cfe_back.sv @@
// Back end: steps the fade accumulators and emits one encoded frame per beat.
module cfe_back (
  input  logic          clk,
  input  logic          rst,
  input  cfe_pkg::cfg_t cfg,
  input  cfe_pkg::job_t head,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output cfe_pkg::res_t out_data
);
  import cfe_pkg::*;

  logic                    busy;
  logic [STEP_W-1:0]       k;
  logic signed [ACC_W-1:0] acc_r, acc_g, acc_b;
  logic                    out_free;
  logic                    fading;

  assign out_free = !out_valid || out_ready;
  assign fading   = k < head.steps;
  assign q_pop    = busy && out_free && !fading;

  // 8.8 start point: previous color plus the first step
  function automatic logic signed [ACC_W-1:0] acc_start(input logic [LVL_W-1:0] prev,
                                                       input logic signed [QUO_W-1:0] step);
    return $signed({{(ACC_W-LVL_W-8){1'b0}}, prev, 8'h00})
         + $signed({{(ACC_W-QUO_W){step[QUO_W-1]}}, step});
  endfunction

  function automatic logic signed [ACC_W-1:0] ext_step(input logic signed [QUO_W-1:0] step);
    return $signed({{(ACC_W-QUO_W){step[QUO_W-1]}}, step});
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a busy back end with a free output reloads the beat below
      if (out_valid && out_ready && !busy) out_valid <= 1'b0;
      if (!busy && !q_empty) begin
        // pick up the next job
        busy  <= 1'b1;
        k     <= STEP_W'(1);
        acc_r <= acc_start(head.prev_r, head.step_r);
        acc_g <= acc_start(head.prev_g, head.step_g);
        acc_b <= acc_start(head.prev_b, head.step_b);
      end else if (busy && out_free) begin
        out_valid <= 1'b1;
        if (fading) begin
          // intermediate color, held one hundredth
          out_data.encoded_frame <= color_frame(cfg.rgb_order, acc_level(acc_r),
                                                acc_level(acc_g), acc_level(acc_b));
          out_data.show_time     <= 8'd1;
          out_data.last_frame    <= 1'b0;
          acc_r <= acc_r + ext_step(head.step_r);
          acc_g <= acc_g + ext_step(head.step_g);
          acc_b <= acc_b + ext_step(head.step_b);
          k     <= k + 1'b1;
        end else begin
          // exact target color ends the command
          out_data.encoded_frame <= color_frame(cfg.rgb_order, head.tgt_r,
                                                head.tgt_g, head.tgt_b);
          out_data.show_time     <= head.hold_time;
          out_data.last_frame    <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

@@ hdl/color_fade_led_uart_encoder_unit.sv @@
// Top level of the color fade encoder: configuration registers, front, queue and back.
//
// Each command yields up to 64 eight-byte UART frames for a serial LED. A command
// with fading off or a step count of one skips the divide and goes straight from
// accept to push. With n steps of two or more, the front accepts it, runs three
// bit-serial dividers side by side, captures the results and pushes the job; the
// back then picks the job up and sends n frames, one per cycle while out_ready
// stays high. A two-entry queue lets the front divide the next command while the
// back is still sending. Registers: index 0 smooth_steps (0 to 64, larger values
// act as 64), index 1 rgb_order; other indexes are ignored. Write them only while
// the block is idle.
module color_fade_led_uart_encoder_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cfe_pkg::cmd_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cfe_pkg::res_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_index,
  input  logic [7:0]    cfg_data
);
  import cfe_pkg::*;

  cfg_t cfg;
  job_t q_in, q_head;
  logic q_push, q_pop, q_full, q_empty;

  assign cfg_ready = !rst;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.smooth_steps <= '0;
      cfg.rgb_order    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SMOOTH_STEPS: cfg.smooth_steps <= cfg_data[STEP_W-1:0];
        REG_RGB_ORDER:    cfg.rgb_order    <= cfg_data[0];
        default:          cfg <= cfg;
      endcase
    end
  end

  cfe_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .cfg(cfg), .q_full(q_full), .q_push(q_push), .q_data(q_in)
  );

  cfe_fifo u_fifo (
    .clk(clk), .rst(rst),
    .push(q_push), .push_data(q_in), .pop(q_pop),
    .head(q_head), .full(q_full), .empty(q_empty)
  );

  cfe_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .head(q_head), .q_empty(q_empty), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

@@ hdl/cfe_checker.sv @@
// Port-level checks of the color fade encoder, bound to the top level.
module cfe_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input cfe_pkg::res_t out_data
);
  import cfe_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Intermediate colors are always held one hundredth
  a_mid_time: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_frame |-> out_data.show_time == 8'd1)
    else $error("intermediate frame with wrong show time");

  // Fixed bits of every UART byte
  a_frame_bits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.encoded_frame & 64'h5B5B_5B5B_5B5B_5B5B)
                  == 64'h1212_1212_1212_1212)
    else $error("frame byte with bad fixed bits");

  // Front takes one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted back to back");

endmodule

bind color_fade_led_uart_encoder_unit cfe_checker u_cfe_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

@@ sim/color_fade_led_uart_encoder_unit_tb.sv @@
// Self-checking testbench for the color fade encoder: directed table, random phases, scoreboard.
module color_fade_led_uart_encoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfe_pkg::*;

  // Longest stretch with no beat on any channel before the run is called hung
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int END_PAUSE = 50;
  localparam int PHASE_CMDS = 55;
  localparam int NUM_PHASES = 8;

  typedef struct packed {
    logic        typed;
    logic [63:0] frame;
  } note_t;

  typedef struct {
    logic [7:0]  steps;
    logic        order;
    cmd_t        cmd;
    logic        typed;
    logic [63:0] frame;
  } row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  cmd_t in_data;
  logic out_valid;
  logic out_ready;
  res_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [7:0] cfg_index;
  logic [7:0] cfg_data;

  // Predictor state: configuration and the color that fades start from
  logic [6:0] cfg_steps;
  logic       cfg_order;
  logic [7:0] lvl_r, lvl_g, lvl_b;

  res_t  frames_due[$];
  note_t cmd_notes[$];
  row_t  directed_rows[$];

  int mismatch_count;
  int cmds_seen;
  int frames_seen;
  int quiet_cycles;
  bit hold_req;
  bit calm;

  color_fade_led_uart_encoder_unit uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Channel order, then three bits per byte, MSB of the word first
  function automatic logic [63:0] encode_color(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
    logic [23:0] word;
    logic [63:0] frame;
    logic [7:0]  byte_bits;
    word = cfg_order ? {r, g, b} : {g, r, b};
    for (int j = 0; j < 8; j++) begin
      byte_bits = BASE_BITS;
      if (word[23 - 3*j]) byte_bits = byte_bits | FIRST_BIT;
      if (word[22 - 3*j]) byte_bits = byte_bits | SECOND_BIT;
      if (word[21 - 3*j]) byte_bits = byte_bits | THIRD_BIT;
      frame[8*j +: 8] = byte_bits;
    end
    return frame;
  endfunction

  // 8.8 level at fade step k, truncated toward zero and clamped
  function automatic logic [7:0] fade_to(input logic [7:0] prev, input int step, input int k);
    int acc;
    acc = (int'(prev) * 256 + k * step) / 256;
    if (acc < 0) acc = 0;
    if (acc > 255) acc = 255;
    return acc[7:0];
  endfunction

  // Queue every frame one command causes and move the fade origin unless fading is off
  function automatic void predict_fade(input cmd_t c);
    int   n;
    int   step_r, step_g, step_b;
    res_t r;
    n = (cfg_steps > MAX_STEPS) ? int'(MAX_STEPS) : int'(cfg_steps);
    if (n != 0) begin
      step_r = ((int'(c.red) - int'(lvl_r)) * 256) / n;
      step_g = ((int'(c.green) - int'(lvl_g)) * 256) / n;
      step_b = ((int'(c.blue) - int'(lvl_b)) * 256) / n;
      for (int k = 1; k < n; k++) begin
        r.encoded_frame = encode_color(fade_to(lvl_r, step_r, k), fade_to(lvl_g, step_g, k),
                                       fade_to(lvl_b, step_b, k));
        r.show_time = 8'd1;
        r.last_frame = 1'b0;
        frames_due.push_back(r);
      end
      lvl_r = c.red;
      lvl_g = c.green;
      lvl_b = c.blue;
    end
    r.encoded_frame = encode_color(c.red, c.green, c.blue);
    r.show_time = c.hold_time;
    r.last_frame = 1'b1;
    frames_due.push_back(r);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Scoreboard: track config beats, predict on command beats, check frame beats
  always @(posedge clk) begin : scoreboard
    res_t  want;
    note_t note;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SMOOTH_STEPS) cfg_steps = cfg_data[6:0];
        else if (cfg_index == REG_RGB_ORDER) cfg_order = cfg_data[0];
      end
      if (in_valid && in_ready) begin
        note = cmd_notes.pop_front();
        predict_fade(in_data);
        if (note.typed) begin
          want = frames_due.pop_back();
          want.encoded_frame = note.frame;
          frames_due.push_back(want);
        end
        cmds_seen++;
      end
      if (out_valid && out_ready) begin
        frames_seen++;
        if (frames_due.size() == 0) begin
          flag_mismatch($sformatf("frame %0d arrived with nothing expected", frames_seen));
        end else begin
          want = frames_due.pop_front();
          if (out_data.encoded_frame !== want.encoded_frame)
            flag_mismatch($sformatf("frame %0d encoded_frame %h, expected %h", frames_seen,
                                    out_data.encoded_frame, want.encoded_frame));
          if (out_data.show_time !== want.show_time)
            flag_mismatch($sformatf("frame %0d show_time %0d, expected %0d", frames_seen,
                                    out_data.show_time, want.show_time));
          if (out_data.last_frame !== want.last_frame)
            flag_mismatch($sformatf("frame %0d last_frame %b, expected %b", frames_seen,
                                    out_data.last_frame, want.last_frame));
        end
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no beat for %0d cycles, %0d frames still due", quiet_cycles, frames_due.size());
      $display("color_fade_led_uart_encoder_unit: mismatch");
      $finish;
    end
  end

  // Frame sink: random stall bursts, one long hold-off on request
  initial begin
    int n;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(0, 9);
        repeat (n) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_cmd(input cmd_t c, input logic typed, input logic [63:0] frame);
    int    gap;
    note_t note;
    note.typed = typed;
    note.frame = frame;
    cmd_notes.push_back(note);
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop offering and let every expected frame come out
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input logic [7:0] steps, input logic order, input logic [7:0] hold,
                         input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                         input logic typed, input logic [63:0] frame);
    row_t row;
    row.steps = steps;
    row.order = order;
    row.cmd.hold_time = hold;
    row.cmd.red = r;
    row.cmd.green = g;
    row.cmd.blue = b;
    row.typed = typed;
    row.frame = frame;
    directed_rows.push_back(row);
  endtask

  // Levels lean toward the extremes a fifth of the time
  function automatic logic [7:0] pick_level();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    logic [7:0] cur_steps;
    logic       cur_order;
    logic [7:0] phase_steps[NUM_PHASES];
    logic       phase_order[NUM_PHASES];
    row_t       row;
    cmd_t       c;

    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    cfg_steps = '0;
    cfg_order = 1'b0;
    lvl_r = '0;
    lvl_g = '0;
    lvl_b = '0;
    mismatch_count = 0;
    cmds_seen = 0;
    frames_seen = 0;
    quiet_cycles = 0;
    hold_req = 1'b0;
    calm = 1'b0;

    // Directed table: fade off with typed frames first, then step counts and orders
    add_row(8'd0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 64'h1212121212121212);
    add_row(8'd0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 64'hB6B6B6B6B6B6B6B6);
    add_row(8'd0, 1'b0, 8'h7F, 8'hFF, 8'h00, 8'h00, 1'b1, 64'h121216B6B6921212);
    add_row(8'd0, 1'b1, 8'h80, 8'hFF, 8'h00, 8'h00, 1'b1, 64'h121212121236B6B6);
    add_row(8'd0, 1'b1, 8'h01, 8'h00, 8'hFF, 8'h00, 1'b0, '0);
    // single step still moves the fade origin
    add_row(8'd1, 1'b1, 8'h10, 8'h12, 8'h34, 8'h56, 1'b0, '0);
    add_row(8'd2, 1'b1, 8'h20, 8'hFF, 8'h00, 8'hFF, 1'b0, '0);
    add_row(8'd2, 1'b1, 8'h40, 8'h00, 8'hFF, 8'h00, 1'b0, '0);
    add_row(8'd64, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0);
    add_row(8'd64, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0);
    add_row(8'd64, 1'b0, 8'hAA, 8'h80, 8'h01, 8'hFE, 1'b0, '0);
    // step counts above the maximum saturate; bit 7 of the write is dropped
    add_row(8'd127, 1'b0, 8'h55, 8'hFF, 8'h00, 8'h80, 1'b0, '0);
    add_row(8'hC0, 1'b1, 8'h33, 8'h00, 8'hFF, 8'h7F, 1'b0, '0);
    // fade off leaves the origin alone, next fade starts from the old one
    add_row(8'd0, 1'b1, 8'h99, 8'h55, 8'hAA, 8'h33, 1'b0, '0);
    add_row(8'd3, 1'b1, 8'h05, 8'h01, 8'h02, 8'h03, 1'b0, '0);
    add_row(8'd7, 1'b0, 8'hFE, 8'hFE, 8'hFD, 8'hFC, 1'b0, '0);
    add_row(8'd7, 1'b0, 8'h01, 8'hFE, 8'hFD, 8'hFC, 1'b0, '0);
    add_row(8'd63, 1'b1, 8'hC8, 8'h00, 8'h00, 8'h00, 1'b0, '0);
    add_row(8'd2, 1'b0, 8'h02, 8'h01, 8'h00, 8'hFF, 1'b0, '0);

    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Walk the table, rewriting registers only when a row asks for a new setting
    cur_steps = 8'd0;
    cur_order = 1'b0;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.steps != cur_steps || row.order != cur_order) begin
        drain();
        if (row.steps != cur_steps) write_reg(REG_SMOOTH_STEPS, row.steps);
        if (row.order != cur_order) write_reg(REG_RGB_ORDER, {7'd0, row.order});
        cur_steps = row.steps;
        cur_order = row.order;
      end
      send_cmd(row.cmd, row.typed, row.frame);
    end

    // An unknown register index must be ignored
    drain();
    write_reg(8'hFF, 8'hFF);

    // Random phases; the full-length fade phase carries the sink hold-off
    phase_steps[0] = 8'd0;   phase_order[0] = 1'b0;
    phase_steps[1] = 8'd1;   phase_order[1] = 1'b1;
    phase_steps[2] = 8'd2;   phase_order[2] = 1'b0;
    phase_steps[3] = 8'd64;  phase_order[3] = 1'b1;
    phase_steps[4] = 8'd100; phase_order[4] = 1'b0;
    phase_steps[5] = 8'($urandom_range(3, 20));  phase_order[5] = 1'b1;
    phase_steps[6] = 8'($urandom_range(2, 10));  phase_order[6] = 1'b0;
    phase_steps[7] = 8'($urandom_range(0, 8));   phase_order[7] = 1'($urandom_range(0, 1));
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_reg(REG_SMOOTH_STEPS, phase_steps[p]);
      write_reg(REG_RGB_ORDER, {7'd0, phase_order[p]});
      if (p == 3) hold_req = 1'b1;
      if (p == NUM_PHASES - 1) calm = 1'b1;
      for (int i = 0; i < PHASE_CMDS; i++) begin
        c.hold_time = 8'($urandom_range(0, 255));
        c.red = pick_level();
        c.green = pick_level();
        c.blue = pick_level();
        send_cmd(c, 1'b0, '0);
      end
    end

    drain();
    repeat (END_PAUSE) @(posedge clk);

    $display("Ran %0d color commands yielding %0d LED frames, both channel orders.",
             cmds_seen, frames_seen);
    $display("Fade off, single step, saturated counts and a long sink hold-off were hit.");
    if (mismatch_count == 0)
      $display("color_fade_led_uart_encoder_unit: match");
    else
      $display("color_fade_led_uart_encoder_unit: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
hdl/cfe_pkg.sv
hdl/cfe_div.sv
hdl/cfe_front.sv
hdl/cfe_fifo.sv
hdl/cfe_back.sv
hdl/color_fade_led_uart_encoder_unit.sv
hdl/cfe_checker.sv
sim/color_fade_led_uart_encoder_unit_tb.sv
